[src/rslw_pkg.sv]
// Shared types, constants and helpers for the ring scheduler with lock wait.
package rslw_pkg;

  localparam int MAX_PROCS    = 128;
  localparam int LOCK_ENTRIES = 16;

  localparam int ID_W      = 8;
  localparam int SLOT_W    = $clog2(MAX_PROCS);
  localparam int LT_IDX_W  = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int LT_CNT_W  = $clog2(LOCK_ENTRIES + 1);
  localparam int KEY_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  localparam logic [7:0] FORK_LIMIT_RST = 8'd100;

  // command codes
  localparam logic [2:0] MODE_BOOT   = 3'd0;
  localparam logic [2:0] MODE_SWITCH = 3'd1;
  localparam logic [2:0] MODE_EXIT   = 3'd2;
  localparam logic [2:0] MODE_ID     = 3'd3;
  localparam logic [2:0] MODE_FORK   = 3'd4;
  localparam logic [2:0] MODE_LOCK   = 3'd5;
  localparam logic [2:0] MODE_UNLOCK = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HALT     = 2'd1;
  localparam logic [1:0] ST_LT_FULL  = 2'd2;
  localparam logic [1:0] ST_FORK_REF = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORK_LIMIT = 1'd1;

  typedef struct packed {
    logic [2:0]       mode;
    logic [KEY_W-1:0] lock_key;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] run_id;
    logic [ID_W-1:0] ret_value;
    logic [ID_W-1:0] child_id;
    logic [1:0]      status;
    logic            now_waiting;
  } out_t;

  // process id i lives in slot i-1; id 0 maps to slot 0
  function automatic logic [SLOT_W-1:0] slot_of(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] d;
    d = id - ID_W'(1);
    return (id == '0) ? '0 : d[SLOT_W-1:0];
  endfunction

endpackage

[src/ring_scheduler_with_lock_wait_unit.sv]
// Ring scheduler with lock wait: top level, sequencer and process/lock stores.
//
// Usage: one command item enters on in_valid/in_ready (in_data.mode, lock_key);
// exactly one result item leaves on out_valid/out_ready (out_data). Registers
// spin_mode (index 0) and fork_limit (index 1) are written through cfg_we,
// cfg_index, cfg_data; the user must write them only while no command is in
// flight, which the block itself does not enforce.
// Steps per item, with P = proc_count: boot goes straight from intake to the
// result. Every other command passes the same intake states, then walks the
// ring for a ready process, one ring entry per cycle through the ring memory
// read port. Then switch and id present their result; exit and lock-wait walk
// the ring again; fork writes the new process (S_FORK1, S_FORK2); lock scans
// the lock table one entry a cycle; unlock reads the held key, scans the table
// and, outside spin mode, sweeps all P wait keys.
// One command is worked at a time; in_ready is low while it runs.
// The result sits in an output register, so the next command is taken while
// it waits; a finished command holds until that register frees.
// Reset (rst, synchronous) empties the scheduler: no process exists until
// boot, and every command but boot reports halted. spin_mode resets to 0,
// fork_limit to 100. Process and lock stores need no clearing pass.
module ring_scheduler_with_lock_wait_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rslw_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rslw_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [rslw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rslw_pkg::CFG_W-1:0]   cfg_data
);
  import rslw_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CMD    = 4'd1;
  localparam logic [3:0] S_WSTART = 4'd2;
  localparam logic [3:0] S_WALK   = 4'd3;
  localparam logic [3:0] S_DISP   = 4'd4;
  localparam logic [3:0] S_FORK1  = 4'd5;
  localparam logic [3:0] S_FORK2  = 4'd6;
  localparam logic [3:0] S_LSCAN  = 4'd7;
  localparam logic [3:0] S_UREAD  = 4'd8;
  localparam logic [3:0] S_USCAN  = 4'd9;
  localparam logic [3:0] S_USWEEP = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0]          state;
  logic [2:0]          mode_r;
  logic [KEY_W-1:0]    key_r;
  logic                spin_mode;
  logic [7:0]          fork_limit;
  logic [ID_W-1:0]     proc_count;
  logic [ID_W-1:0]     current_id;
  logic [LT_CNT_W-1:0] lt_used;
  logic [KEY_W-1:0]    lt_key  [LOCK_ENTRIES];
  logic                lt_free [LOCK_ENTRIES];
  logic [LT_CNT_W-1:0] lt_i;
  out_t                res;
  logic                walk_post;
  logic [ID_W-1:0]     prev_id;
  logic                have_prev;
  logic [ID_W-1:0]     chk;
  logic [ID_W-1:0]     found;
  logic [KEY_W-1:0]    ukey;
  logic [ID_W-1:0]     sw_i;
  logic [SLOT_W-1:0]   sw_prev;
  logic                sw_pv;

  // process stores
  logic [ID_W-1:0]  ring_mem [MAX_PROCS];
  logic             ex_mem   [MAX_PROCS];
  logic [KEY_W-1:0] wk_mem   [MAX_PROCS];
  logic [KEY_W-1:0] hk_mem   [MAX_PROCS];
  logic [ID_W-1:0]  ring_q;
  logic             ex_q;
  logic [KEY_W-1:0] wk_q;
  logic [KEY_W-1:0] hk_q;

  logic [SLOT_W-1:0] ring_ra, st_ra, hk_ra;
  logic              ring_we, ex_we, wk_we, hk_we;
  logic [SLOT_W-1:0] ring_wa, ex_wa, wk_wa, hk_wa;
  logic [ID_W-1:0]   ring_wd;
  logic              ex_wd;
  logic [KEY_W-1:0]  wk_wd, hk_wd;

  logic [SLOT_W-1:0]   cur_slot;
  logic [ID_W-1:0]     nid;
  logic [ID_W-1:0]     chk_inc;
  logic                proc_ready;
  logic [LT_IDX_W-1:0] lt_idx;
  logic                lt_in;
  logic                lk_acq, lk_busy, lk_full, uk_hit;
  logic                fork_ok;

  function automatic out_t mk_res(input logic [ID_W-1:0] run, input logic [ID_W-1:0] ret,
                                  input logic [ID_W-1:0] child, input logic [1:0] st,
                                  input logic waiting);
    out_t r;
    r.run_id      = run;
    r.ret_value   = ret;
    r.child_id    = child;
    r.status      = st;
    r.now_waiting = waiting;
    return r;
  endfunction

  assign in_ready   = (state == S_IDLE);
  assign cur_slot   = slot_of(current_id);
  assign nid        = proc_count + ID_W'(1);
  assign chk_inc    = chk + ID_W'(1);
  assign proc_ready = !ex_q && (wk_q == '0);
  assign lt_idx     = lt_i[LT_IDX_W-1:0];
  assign lt_in      = (lt_i < lt_used);
  assign lk_acq     = (lt_in && lt_key[lt_idx] == key_r && lt_free[lt_idx]) ||
                      (!lt_in && lt_used < LT_CNT_W'(LOCK_ENTRIES));
  assign lk_busy    = lt_in && lt_key[lt_idx] == key_r && !lt_free[lt_idx];
  assign lk_full    = !lt_in && lt_used >= LT_CNT_W'(LOCK_ENTRIES);
  assign uk_hit     = lt_in && lt_key[lt_idx] == ukey;
  assign fork_ok    = (proc_count < fork_limit) && (proc_count < ID_W'(MAX_PROCS));

  // store read addresses and write controls
  always_comb begin
    ring_ra = slot_of(ring_q);
    st_ra   = slot_of(ring_q);
    hk_ra   = cur_slot;
    ring_we = 1'b0; ring_wa = cur_slot; ring_wd = ring_q;
    ex_we   = 1'b0; ex_wa   = cur_slot; ex_wd   = 1'b0;
    wk_we   = 1'b0; wk_wa   = cur_slot; wk_wd   = '0;
    hk_we   = 1'b0; hk_wa   = cur_slot; hk_wd   = '0;
    unique case (state)
      S_CMD: begin
        if (mode_r == MODE_BOOT) begin
          ring_we = 1'b1; ring_wa = '0; ring_wd = ID_W'(1);
          ex_we   = 1'b1; ex_wa   = '0;
          wk_we   = 1'b1; wk_wa   = '0;
          hk_we   = 1'b1; hk_wa   = '0;
        end
      end
      S_WSTART: ring_ra = cur_slot;
      S_DISP: begin
        ring_ra = cur_slot;
        if (!walk_post && found != '0 && mode_r == MODE_EXIT) begin
          ex_we = 1'b1; ex_wd = 1'b1;
          hk_we = 1'b1;
        end
      end
      S_FORK1: begin
        ring_we = 1'b1; ring_wa = proc_count[SLOT_W-1:0];
        ex_we   = 1'b1; ex_wa   = proc_count[SLOT_W-1:0];
        wk_we   = 1'b1; wk_wa   = proc_count[SLOT_W-1:0];
        hk_we   = 1'b1; hk_wa   = proc_count[SLOT_W-1:0];
      end
      S_FORK2: begin
        ring_we = 1'b1; ring_wd = nid;
      end
      S_LSCAN: begin
        if (lk_acq) begin
          hk_we = 1'b1; hk_wd = key_r;
        end else if (lk_busy && !spin_mode) begin
          wk_we = 1'b1; wk_wd = key_r;
        end
      end
      S_UREAD: hk_we = 1'b1;
      S_USWEEP: begin
        st_ra = sw_i[SLOT_W-1:0];
        if (sw_pv && wk_q == ukey) begin
          wk_we = 1'b1; wk_wa = sw_prev;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    ring_q <= ring_mem[ring_ra];
  end

  always_ff @(posedge clk) begin
    if (ex_we) ex_mem[ex_wa] <= ex_wd;
    ex_q <= ex_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (wk_we) wk_mem[wk_wa] <= wk_wd;
    wk_q <= wk_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (hk_we) hk_mem[hk_wa] <= hk_wd;
    hk_q <= hk_mem[hk_ra];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      spin_mode  <= 1'b0;
      fork_limit <= FORK_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPIN_MODE:  spin_mode  <= cfg_data[0];
        CFG_FORK_LIMIT: fork_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      proc_count <= '0;
      current_id <= '0;
      lt_used    <= '0;
      walk_post  <= 1'b0;
      have_prev  <= 1'b0;
      sw_pv      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= in_data.mode;
            key_r  <= in_data.lock_key;
            state  <= S_CMD;
          end
        end
        S_CMD: begin
          if (mode_r == MODE_BOOT) begin
            proc_count  <= ID_W'(1);
            current_id  <= ID_W'(1);
            lt_used     <= '0;
            res         <= mk_res(ID_W'(1), '0, '0, ST_OK, 1'b0);
            state       <= S_FIN;
          end else begin
            walk_post <= 1'b0;
            state     <= S_WSTART;
          end
        end
        S_WSTART: begin
          have_prev <= 1'b0;
          chk       <= '0;
          if (proc_count == '0) begin
            found <= '0;
            state <= S_DISP;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          // ring_q is the next candidate; ex_q/wk_q belong to prev_id
          prev_id   <= ring_q;
          have_prev <= 1'b1;
          if (have_prev) begin
            if (proc_ready) begin
              found <= prev_id;
              state <= S_DISP;
            end else begin
              chk <= chk_inc;
              if (chk_inc == proc_count) begin
                found <= '0;
                state <= S_DISP;
              end
            end
          end
        end
        S_DISP: begin
          if (walk_post) begin
            if (found != '0) current_id <= found;
            res   <= mk_res(found, '0, '0, (found != '0) ? ST_OK : ST_HALT,
                            mode_r == MODE_LOCK);
            state <= S_FIN;
          end else if (found == '0) begin
            res   <= mk_res('0, '0, '0, ST_HALT, 1'b0);
            state <= S_FIN;
          end else begin
            unique case (mode_r)
              MODE_SWITCH: begin
                current_id <= found;
                res        <= mk_res(found, '0, '0, ST_OK, 1'b0);
                state      <= S_FIN;
              end
              MODE_EXIT: begin
                walk_post <= 1'b1;
                state     <= S_WSTART;
              end
              MODE_ID: begin
                res   <= mk_res(current_id, current_id, '0, ST_OK, 1'b0);
                state <= S_FIN;
              end
              MODE_FORK: begin
                if (fork_ok) begin
                  state <= S_FORK1;
                end else begin
                  res   <= mk_res(current_id, '0, '0, ST_FORK_REF, 1'b0);
                  state <= S_FIN;
                end
              end
              MODE_LOCK: begin
                res   <= mk_res(current_id, '0, '0, ST_OK, 1'b0);
                lt_i  <= '0;
                state <= S_LSCAN;
              end
              MODE_UNLOCK: begin
                res   <= mk_res(current_id, '0, '0, ST_OK, 1'b0);
                state <= S_UREAD;
              end
              default: begin
                res   <= mk_res(current_id, '0, '0, ST_OK, 1'b0);
                state <= S_FIN;
              end
            endcase
          end
        end
        S_FORK1: state <= S_FORK2;
        S_FORK2: begin
          proc_count <= nid;
          res        <= mk_res(current_id, nid, nid, ST_OK, 1'b0);
          state      <= S_FIN;
        end
        S_LSCAN: begin
          if (lt_in && lt_key[lt_idx] == key_r) begin
            if (lt_free[lt_idx]) lt_free[lt_idx] <= 1'b0;
          end else if (!lt_in && !lk_full) begin
            lt_key[lt_used[LT_IDX_W-1:0]]  <= key_r;
            lt_free[lt_used[LT_IDX_W-1:0]] <= 1'b0;
            lt_used                        <= lt_used + LT_CNT_W'(1);
          end
          if (lk_acq) begin
            res.ret_value <= ID_W'(1);
            state         <= S_FIN;
          end else if (lk_full) begin
            res.status <= ST_LT_FULL;
            state      <= S_FIN;
          end else if (lk_busy) begin
            if (spin_mode) begin
              state <= S_FIN;
            end else begin
              walk_post <= 1'b1;
              state     <= S_WSTART;
            end
          end else begin
            lt_i <= lt_i + LT_CNT_W'(1);
          end
        end
        S_UREAD: begin
          ukey  <= hk_q;
          lt_i  <= '0;
          state <= S_USCAN;
        end
        S_USCAN: begin
          if (uk_hit) lt_free[lt_idx] <= 1'b1;
          if (uk_hit || !lt_in) begin
            sw_i  <= '0;
            sw_pv <= 1'b0;
            state <= spin_mode ? S_FIN : S_USWEEP;
          end else begin
            lt_i <= lt_i + LT_CNT_W'(1);
          end
        end
        S_USWEEP: begin
          if (sw_i < proc_count) begin
            sw_prev <= sw_i[SLOT_W-1:0];
            sw_pv   <= 1'b1;
            sw_i    <= sw_i + ID_W'(1);
          end else begin
            sw_pv <= 1'b0;
            if (!sw_pv) state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      out_data  <= res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_pc_bound: assert property (@(posedge clk) disable iff (rst)
    proc_count <= ID_W'(MAX_PROCS))
    else $error("process count beyond ring size");

  a_lt_bound: assert property (@(posedge clk) disable iff (rst)
    lt_used <= LT_CNT_W'(LOCK_ENTRIES))
    else $error("lock table overfilled");

  a_cur_live: assert property (@(posedge clk) disable iff (rst)
    proc_count != '0 |-> (current_id != '0 && current_id <= proc_count))
    else $error("current process id out of range");

  a_halt_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_HALT) |-> out_data.run_id == '0)
    else $error("halted result names a process");
`endif

endmodule
